// ===== hdl/wbps_pkg.sv =====
// Shared types and constants for the wildcard byte pattern scanner.
package wbps_pkg;

    // Pattern storage: four 64-bit words, eight bytes each
    localparam int PAT_WORDS  = 4;
    localparam int PAT_BYTES  = 32;
    localparam int LEN_W      = 6;
    localparam int CFG_ADDR_W = 6;
    localparam int CFG_DATA_W = 64;

    // Pattern byte that matches any data byte
    localparam logic [7:0] WILDCARD_BYTE = 8'hCC;

    // Result status codes
    localparam logic [1:0] ST_FOUND     = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_INVALID   = 2'd2;

    // Register indexes (byte address / 8)
    localparam logic [2:0] REG_PAT0 = 3'd0;
    localparam logic [2:0] REG_PAT1 = 3'd1;
    localparam logic [2:0] REG_PAT2 = 3'd2;
    localparam logic [2:0] REG_PAT3 = 3'd3;
    localparam logic [2:0] REG_LEN  = 3'd4;

    // Live configuration seen by the compare stage
    typedef struct packed {
        logic [PAT_BYTES*8-1:0] pattern;
        logic [LEN_W-1:0]       length;
    } t_cfg;

    // Control of the word held in the window stage
    typedef struct packed {
        logic vld;
        logic last;
    } t_s1;

endpackage

// ===== hdl/wbps_cfg.sv =====
// Configuration register file with APB-style access.
module wbps_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_psel,
    input  logic                               i_penable,
    input  logic                               i_pwrite,
    input  logic [wbps_pkg::CFG_ADDR_W-1:0]    i_paddr,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]    i_pwdata,
    output logic [wbps_pkg::CFG_DATA_W-1:0]    o_prdata,
    output wbps_pkg::t_cfg                     o_cfg
);
    import wbps_pkg::*;

    logic [PAT_WORDS-1:0][63:0] r_pat;
    logic [LEN_W-1:0]           r_len;
    logic                       w_wr;
    logic [2:0]                 w_idx;

    assign w_wr  = i_psel && i_penable && i_pwrite;
    assign w_idx = i_paddr[5:3];

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat <= '0;
            r_len <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_PAT0: r_pat[0] <= i_pwdata;
                REG_PAT1: r_pat[1] <= i_pwdata;
                REG_PAT2: r_pat[2] <= i_pwdata;
                REG_PAT3: r_pat[3] <= i_pwdata;
                REG_LEN:  r_len    <= i_pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (w_idx)
            REG_PAT0: o_prdata = r_pat[0];
            REG_PAT1: o_prdata = r_pat[1];
            REG_PAT2: o_prdata = r_pat[2];
            REG_PAT3: o_prdata = r_pat[3];
            REG_LEN:  o_prdata = CFG_DATA_W'(r_len);
            default:  o_prdata = '0;
        endcase
    end

    assign o_cfg.pattern = r_pat;
    assign o_cfg.length  = r_len;

endmodule

// ===== hdl/wbps_win.sv =====
// Input stage: sliding byte window and saturating region byte count.
module wbps_win #(
    parameter int MAX_PATTERN = 32,
    parameter int OFFSET_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [7:0]                        i_data,
    input  logic                              i_last,
    output logic                              o_stall,
    input  logic                              i_take,
    output wbps_pkg::t_s1                     o_s1,
    output logic [MAX_PATTERN-1:0][7:0]       o_win,
    output logic [OFFSET_BITS-1:0]            o_cnt
);
    import wbps_pkg::*;

    logic                          r_vld;
    logic                          r_last;
    logic [MAX_PATTERN-1:0][7:0]   r_win;
    logic [OFFSET_BITS-1:0]        r_cnt;
    logic [OFFSET_BITS-1:0]        w_base;
    logic [OFFSET_BITS-1:0]        n_cnt;
    logic                          w_acc;

    // Stage is free when empty or when its word moves on this cycle
    assign w_acc   = i_valid && (!r_vld || i_take);
    assign o_stall = r_vld && !i_take;

    // A new region starts counting from zero after a last byte
    assign w_base = r_last ? '0 : r_cnt;
    assign n_cnt  = (&w_base) ? w_base : w_base + 1'b1;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_last <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (w_acc) begin
                r_vld  <= 1'b1;
                r_last <= i_last;
                r_cnt  <= n_cnt;
            end else if (i_take) begin
                r_vld  <= 1'b0;
            end
        end
    end

    // Window shift, newest byte in the top slot; stale bytes are never
    // compared because the count gate excludes them
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            for (int k = 0; k < MAX_PATTERN - 1; k++) begin
                r_win[k] <= r_win[k+1];
            end
            r_win[MAX_PATTERN-1] <= i_data;
        end
    end

    assign o_s1.vld  = r_vld;
    assign o_s1.last = r_last;
    assign o_win     = r_win;
    assign o_cnt     = r_cnt;

endmodule

// ===== hdl/wbps_match.sv =====
// Compare stage: wildcard window match, found latch and result register.
module wbps_match #(
    parameter int MAX_PATTERN = 32,
    parameter int OFFSET_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  wbps_pkg::t_cfg                    i_cfg,
    input  wbps_pkg::t_s1                     i_s1,
    input  logic [MAX_PATTERN-1:0][7:0]       i_win,
    input  logic [OFFSET_BITS-1:0]            i_cnt,
    output logic                              o_take,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [1:0]                        o_status,
    output logic [31:0]                       o_match_offset
);
    import wbps_pkg::*;

    localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic                    r_rep;
    logic                    r_vld;
    logic [1:0]              r_status;
    logic [31:0]             r_offset;
    logic [LEN_W-1:0]        w_len;
    logic [6:0]              w_idx;
    logic                    w_win_ok;
    logic                    w_cnt_ok;
    logic                    w_hit;
    logic                    w_produce;
    logic                    w_load;
    logic [OFFSET_BITS-1:0]  w_diff;
    logic [1:0]              w_status;

    // Length clamped to the window depth
    assign w_len = (i_cfg.length > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : i_cfg.length;

    // Parallel compare of the newest w_len bytes against the pattern
    always_comb begin
        w_win_ok = 1'b1;
        w_idx    = '0;
        for (int j = 0; j < MAX_PATTERN; j++) begin
            w_idx = 7'(MAX_PATTERN) - {1'b0, w_len} + 7'(j);
            if (7'(j) < {1'b0, w_len}) begin
                if (i_cfg.pattern[j*8 +: 8] != WILDCARD_BYTE &&
                    i_win[w_idx[IW-1:0]] != i_cfg.pattern[j*8 +: 8]) begin
                    w_win_ok = 1'b0;
                end
            end
        end
    end

    assign w_cnt_ok = i_cnt >= OFFSET_BITS'(w_len);
    assign w_hit    = (w_len != '0) && !r_rep && w_cnt_ok && w_win_ok;
    assign w_diff   = i_cnt - OFFSET_BITS'(w_len);

    // Result decision for the word in the window stage
    always_comb begin
        if (w_len == '0) begin
            w_produce = i_s1.last;
            w_status  = ST_INVALID;
        end else begin
            w_produce = w_hit || (!r_rep && i_s1.last);
            w_status  = w_hit ? ST_FOUND : ST_NOT_FOUND;
        end
    end

    assign o_take = i_s1.vld && (!w_produce || !r_vld || !i_stall);
    assign w_load = o_take && w_produce;

    // Found latch, cleared at the end of each region
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rep <= 1'b0;
        end else if (o_take) begin
            if (i_s1.last) begin
                r_rep <= 1'b0;
            end else if (w_hit) begin
                r_rep <= 1'b1;
            end
        end
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_load) begin
            r_vld <= 1'b1;
        end else if (!i_stall) begin
            r_vld <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_status <= w_status;
            r_offset <= w_hit ? 32'(w_diff) : '0;
        end
    end

    assign o_valid        = r_vld;
    assign o_status       = r_status;
    assign o_match_offset = r_offset;

`ifndef SYNTHESIS
    // Only a found result carries an offset
    a_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && r_status != ST_FOUND |-> r_offset == '0)
        else $error("nonzero offset on a result other than found");

    // A found word inside a region sets the latch
    a_latch_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take && w_hit && !i_s1.last |=> r_rep)
        else $error("found latch not set after a match");

    // At most one found per region
    a_single_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rep |-> !w_hit)
        else $error("second match reported in one region");

    // A result is never dropped while the output is stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && i_stall |-> !w_load)
        else $error("result register overwritten while stalled");
`endif

endmodule

// ===== hdl/wildcard_byte_pattern_scanner_unit.sv =====
// Structure: each byte is registered in the window stage, then compared, and a result is registered.
// Throughput: one byte per cycle while o_in_stall is low; the window register and the parallel pattern
// compare are separate steps, and the result register frees the input side.
// Reset (synchronous, active low) clears pattern registers, byte count, found
// latch and valid flags; the window needs no clearing.
// Top level: wildcard byte pattern scanner.
module wildcard_byte_pattern_scanner_unit #(
    parameter int MAX_PATTERN = 32,
    parameter int OFFSET_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input words
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [7:0]                        i_data_byte,
    input  logic                              i_last_byte,
    // Result words
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [1:0]                        o_status,
    output logic [31:0]                       o_match_offset,
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [wbps_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [wbps_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import wbps_pkg::*;

    t_cfg                          w_cfg;
    t_s1                           w_s1;
    logic [MAX_PATTERN-1:0][7:0]   w_win;
    logic [OFFSET_BITS-1:0]        w_cnt;
    logic                          w_take;

    assign pready = 1'b1;

    wbps_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (w_cfg)
    );

    wbps_win #(
        .MAX_PATTERN (MAX_PATTERN),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_win (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_data  (i_data_byte),
        .i_last  (i_last_byte),
        .o_stall (o_in_stall),
        .i_take  (w_take),
        .o_s1    (w_s1),
        .o_win   (w_win),
        .o_cnt   (w_cnt)
    );

    wbps_match #(
        .MAX_PATTERN (MAX_PATTERN),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_match (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_s1           (w_s1),
        .i_win          (w_win),
        .i_cnt          (w_cnt),
        .o_take         (w_take),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_status       (o_status),
        .o_match_offset (o_match_offset)
    );

endmodule
